// ----- sv/mirsd_pkg.sv -----
package mirsd_pkg;

    localparam int CHANNELS_DEF = 7;
    localparam int MAX_CHANNELS = 8;
    localparam int SYM_W        = 2;
    localparam int DATA_W       = 8;
    localparam int MASK_W       = 7;
    localparam int CNT_W        = 3;
    localparam int ADDR_W       = 4;
    localparam int PDATA_W      = 32;
    localparam int LOW_CHANNELS = 4;

    localparam logic [1:0] REG_START_CODE = 2'd0;
    localparam logic [1:0] REG_ZERO_CODE  = 2'd1;
    localparam logic [1:0] REG_ONE_CODE   = 2'd2;

    localparam logic [SYM_W-1:0] START_CODE_RST = 2'd3;
    localparam logic [SYM_W-1:0] ZERO_CODE_RST  = 2'd1;
    localparam logic [SYM_W-1:0] ONE_CODE_RST   = 2'd2;

    localparam logic [DATA_W-1:0] MSB_MASK = 8'h80;
    localparam logic [CNT_W-1:0]  LAST_BIT = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] first_byte;
        logic [DATA_W-1:0] second_byte;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] direction_mask;
        logic [DATA_W-1:0] data_byte;
    } out_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] start_code;
        logic [SYM_W-1:0] zero_code;
        logic [SYM_W-1:0] one_code;
    } cfg_t;

    typedef struct packed {
        logic              finish;
        logic [DATA_W-1:0] data;
    } lane_res_t;

endpackage

// ----- sv/mirsd_lane.sv -----
module mirsd_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [mirsd_pkg::SYM_W-1:0] sym,
    input  mirsd_pkg::cfg_t             cfg,
    output mirsd_pkg::lane_res_t        res
);

    logic                          collecting_reg, collecting_next;
    logic [mirsd_pkg::CNT_W-1:0]   bit_count_reg, bit_count_next;
    logic [mirsd_pkg::DATA_W-1:0]  assembled_reg, assembled_next;
    logic [mirsd_pkg::DATA_W-1:0]  bit_mask;
    logic                          finish;

    assign bit_mask = mirsd_pkg::MSB_MASK >> bit_count_reg;

    always_comb begin
        collecting_next = collecting_reg;
        bit_count_next  = bit_count_reg;
        assembled_next  = assembled_reg;
        finish          = 1'b0;
        if (accept) begin
            if (!collecting_reg) begin
                if (sym == cfg.start_code) begin
                    collecting_next = 1'b1;
                    bit_count_next  = '0;
                    assembled_next  = '0;
                end
            end else if (sym == cfg.zero_code || sym == cfg.one_code) begin
                if (sym != cfg.zero_code) begin
                    assembled_next = assembled_reg | bit_mask;
                end
                if (bit_count_reg == mirsd_pkg::LAST_BIT) begin
                    bit_count_next  = '0;
                    collecting_next = 1'b0;
                    finish          = 1'b1;
                end else begin
                    bit_count_next = bit_count_reg + 1'b1;
                end
            end else if (sym == cfg.start_code) begin
                collecting_next = 1'b1;
                bit_count_next  = '0;
                assembled_next  = '0;
            end else begin
                collecting_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            bit_count_reg  <= '0;
            assembled_reg  <= '0;
        end else begin
            collecting_reg <= collecting_next;
            bit_count_reg  <= bit_count_next;
            assembled_reg  <= assembled_next;
        end
    end

    assign res.finish = finish;
    assign res.data   = assembled_next;

endmodule

// ----- sv/mirsd_merge.sv -----
module mirsd_merge #(
    parameter int CHANNELS = mirsd_pkg::CHANNELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  mirsd_pkg::lane_res_t lane_res [CHANNELS],
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mirsd_pkg::out_item_t out_item
);

    logic [CHANNELS-1:0]                   mask;
    logic [mirsd_pkg::MAX_CHANNELS-1:0]    mask_wide;
    logic [mirsd_pkg::DATA_W-1:0]          first_data;
    mirsd_pkg::out_item_t                  new_item;
    logic                                  push, pop;

    logic                 head_valid_reg, head_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    mirsd_pkg::out_item_t head_reg, head_next;
    mirsd_pkg::out_item_t skid_reg, skid_next;

    // lowest numbered finished channel wins
    always_comb begin
        first_data = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            mask[c] = lane_res[c].finish;
            if (lane_res[c].finish) begin
                first_data = lane_res[c].data;
            end
        end
    end

    assign mask_wide               = mirsd_pkg::MAX_CHANNELS'(mask);
    assign new_item.direction_mask = mask_wide[mirsd_pkg::MASK_W-1:0];
    assign new_item.data_byte      = first_data;

    assign push     = accept && (|mask);
    assign pop      = head_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!head_valid_reg || pop) begin
            head_valid_next = skid_valid_reg || push;
            head_next       = skid_valid_reg ? skid_reg : new_item;
            skid_valid_next = 1'b0;
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = new_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid = head_valid_reg;
    assign out_item  = head_reg;

    a_skid_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid stage holds an item while output stage is empty");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !accept)
        else $error("item accepted while both result stages are full");

    a_held_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid_reg && !out_ready && push) |=> (skid_valid_reg && head_valid_reg))
        else $error("new result lost behind stalled output");

endmodule

// ----- sv/multichannel_ir_symbol_deframer_core.sv -----
// A result is registered into the output stage, or into the skid stage while m_ready holds it, and shown on m_valid.
// Throughput: one item per cycle while s_ready is high; all channel deframers update in parallel lanes.
// A two-entry output stage lets input keep flowing while one result waits.
// Reset (aresetn low, synchronous): all channels idle, counts and data cleared,
// symbol codes back to start=3, zero=1, one=2, output stages empty.
module multichannel_ir_symbol_deframer_core #(
    parameter int CHANNELS = mirsd_pkg::CHANNELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mirsd_pkg::in_item_t           s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mirsd_pkg::out_item_t          m_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mirsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [mirsd_pkg::PDATA_W-1:0] pwdata,
    output logic [mirsd_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);

    mirsd_pkg::cfg_t      cfg_reg, cfg_next;
    logic [1:0]           reg_idx;
    logic                 wr_en;
    logic                 accept;
    mirsd_pkg::lane_res_t lane_res [CHANNELS];

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        prdata   = '0;
        case (reg_idx)
            mirsd_pkg::REG_START_CODE: begin
                prdata = mirsd_pkg::PDATA_W'(cfg_reg.start_code);
                if (wr_en) cfg_next.start_code = pwdata[mirsd_pkg::SYM_W-1:0];
            end
            mirsd_pkg::REG_ZERO_CODE: begin
                prdata = mirsd_pkg::PDATA_W'(cfg_reg.zero_code);
                if (wr_en) cfg_next.zero_code = pwdata[mirsd_pkg::SYM_W-1:0];
            end
            mirsd_pkg::REG_ONE_CODE: begin
                prdata = mirsd_pkg::PDATA_W'(cfg_reg.one_code);
                if (wr_en) cfg_next.one_code = pwdata[mirsd_pkg::SYM_W-1:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code <= mirsd_pkg::START_CODE_RST;
            cfg_reg.zero_code  <= mirsd_pkg::ZERO_CODE_RST;
            cfg_reg.one_code   <= mirsd_pkg::ONE_CODE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = s_valid && s_ready;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        logic [mirsd_pkg::SYM_W-1:0] sym;
        if (c < mirsd_pkg::LOW_CHANNELS) begin : g_low
            assign sym = s_item.second_byte[mirsd_pkg::SYM_W*c +: mirsd_pkg::SYM_W];
        end else begin : g_high
            assign sym = s_item.first_byte[mirsd_pkg::SYM_W*(c - mirsd_pkg::LOW_CHANNELS)
                                           +: mirsd_pkg::SYM_W];
        end
        mirsd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .accept  (accept),
            .sym     (sym),
            .cfg     (cfg_reg),
            .res     (lane_res[c])
        );
    end

    mirsd_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .lane_res  (lane_res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_item)
    );

endmodule

// ----- sim/tb_multichannel_ir_symbol_deframer_core.sv -----
module tb_multichannel_ir_symbol_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mirsd_pkg::*;

    localparam int STALL_LIMIT      = 3000;
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 4;
    localparam int RANDOM_PER_PHASE = 221;
    localparam int MAX_REPORTED     = 10;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [1:0] NOISE_SYM  = 2'd0;

    localparam logic [DATA_W-1:0] DIRECTED_BYTES [CHANNELS_DEF] =
        '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h80, 8'h01, 8'h3C};

    class channel_byte_tracker;
        logic [SYM_W-1:0]  start_sym;
        logic [SYM_W-1:0]  zero_sym;
        logic [SYM_W-1:0]  one_sym;
        bit                collecting [MAX_CHANNELS];
        logic [CNT_W-1:0]  bit_cnt [MAX_CHANNELS];
        logic [DATA_W-1:0] assembled [MAX_CHANNELS];
        out_item_t         expected_reports [$];
        int                errors;

        function new();
            start_sym = START_CODE_RST;
            zero_sym  = ZERO_CODE_RST;
            one_sym   = ONE_CODE_RST;
            errors    = 0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                collecting[c] = 1'b0;
                bit_cnt[c]    = '0;
                assembled[c]  = '0;
            end
        endfunction

        function void load_code(logic [1:0] idx, logic [PDATA_W-1:0] word);
            case (idx)
                REG_START_CODE: start_sym = word[SYM_W-1:0];
                REG_ZERO_CODE:  zero_sym  = word[SYM_W-1:0];
                REG_ONE_CODE:   one_sym   = word[SYM_W-1:0];
                default: ;
            endcase
        endfunction

        function void absorb(in_item_t it);
            logic [2*DATA_W-1:0] raw;
            logic [SYM_W-1:0]    sym;
            logic [MASK_W-1:0]   mask;
            logic [DATA_W-1:0]   first_data;
            bit                  done;
            out_item_t           rep;
            raw        = it;
            mask       = '0;
            first_data = '0;
            for (int c = 0; c < CHANNELS_DEF; c++) begin
                sym  = raw[2*c +: 2];
                done = 1'b0;
                if (!collecting[c]) begin
                    if (sym == start_sym) begin
                        collecting[c] = 1'b1;
                        bit_cnt[c]    = '0;
                        assembled[c]  = '0;
                    end
                end else if (sym == zero_sym || sym == one_sym) begin
                    if (sym != zero_sym)
                        assembled[c] = assembled[c] | (MSB_MASK >> bit_cnt[c]);
                    if (bit_cnt[c] == LAST_BIT) begin
                        bit_cnt[c]    = '0;
                        collecting[c] = 1'b0;
                        done          = 1'b1;
                    end else begin
                        bit_cnt[c] = bit_cnt[c] + 1'b1;
                    end
                end else if (sym == start_sym) begin
                    bit_cnt[c]   = '0;
                    assembled[c] = '0;
                end else begin
                    collecting[c] = 1'b0;
                end
                if (done) begin
                    if (mask == '0)
                        first_data = assembled[c];
                    mask[c] = 1'b1;
                end
            end
            if (mask != '0) begin
                rep.direction_mask = mask;
                rep.data_byte      = first_data;
                expected_reports.push_back(rep);
            end
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTED)
                $display("mismatch: %s", msg);
        endfunction

        function void match_report(out_item_t got);
            out_item_t want;
            if (expected_reports.size() == 0) begin
                flag($sformatf("unexpected item mask=%h byte=%h",
                               got.direction_mask, got.data_byte));
                return;
            end
            want = expected_reports.pop_front();
            if (got.direction_mask !== want.direction_mask)
                flag($sformatf("direction_mask expected %h got %h",
                               want.direction_mask, got.direction_mask));
            if (got.data_byte !== want.data_byte)
                flag($sformatf("data_byte expected %h got %h",
                               want.data_byte, got.data_byte));
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void close_out();
            while (expected_reports.size() != 0) begin
                flag($sformatf("missing item mask=%h byte=%h",
                               expected_reports[0].direction_mask,
                               expected_reports[0].data_byte));
                void'(expected_reports.pop_front());
            end
        endfunction
    endclass

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_item  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_item;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_W-1:0]    paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    channel_byte_tracker sb;
    int idle_mode    = 0;
    int items_sent   = 0;
    int hold_reqs    = 0;
    int hold_done    = 0;
    int hold_cnt     = 0;
    int stall_cycles = 0;

    multichannel_ir_symbol_deframer_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int tx_idle_pct(int mode);
        case (mode)
            0:       return 26;
            1:       return 53;
            default: return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct(int mode);
        case (mode)
            0:       return 53;
            1:       return 26;
            default: return 0;
        endcase
    endfunction

    // receive side: random backpressure plus the long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.match_report(m_item);
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (hold_reqs != hold_done) begin
            hold_done <= hold_done + 1;
            hold_cnt  <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct(idle_mode));
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic in_item_t pack_syms(logic [2*CHANNELS_DEF-1:0] syms,
                                           logic [1:0] spare);
        return in_item_t'({spare, syms});
    endfunction

    function automatic in_item_t random_item();
        logic [2*DATA_W-1:0] raw;
        int r;
        raw = 16'($urandom());
        for (int c = 0; c < CHANNELS_DEF; c++) begin
            r = $urandom_range(0, 99);
            if (!sb.collecting[c]) begin
                if (r < 55)
                    raw[2*c +: 2] = sb.start_sym;
            end else if (r < 88) begin
                raw[2*c +: 2] = $urandom_range(0, 1) ? sb.one_sym : sb.zero_sym;
            end else if (r < 93) begin
                raw[2*c +: 2] = sb.start_sym;
            end
        end
        return in_item_t'(raw);
    endfunction

    task automatic send_item(input in_item_t it);
        if ($urandom_range(0, 99) < tx_idle_pct(idle_mode)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < tx_idle_pct(idle_mode))
                @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.absorb(it);
        items_sent++;
        idle_mode <= (items_sent < 450) ? 0 : ((items_sent < 900) ? 1 : 2);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [SYM_W-1:0] code);
        logic [PDATA_W-1:0] word;
        word      = $urandom();
        word[1:0] = code;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.load_code(idx, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_codes(input logic [SYM_W-1:0] start_v,
                             input logic [SYM_W-1:0] zero_v,
                             input logic [SYM_W-1:0] one_v);
        drain();
        apb_write(REG_START_CODE, start_v);
        apb_write(REG_ZERO_CODE, zero_v);
        apb_write(REG_ONE_CODE, one_v);
    endtask

    task automatic run_random(input int n);
        repeat (n) send_item(random_item());
    endtask

    task automatic run_directed();
        logic [2*CHANNELS_DEF-1:0] syms;
        send_item(pack_syms({CHANNELS_DEF{NOISE_SYM}}, 2'b11));
        send_item(pack_syms({CHANNELS_DEF{ZERO_CODE_RST}}, 2'b00));
        send_item(pack_syms({CHANNELS_DEF{ONE_CODE_RST}}, 2'b01));
        send_item(pack_syms({CHANNELS_DEF{START_CODE_RST}}, 2'b10));
        // every channel assembles a different byte, all finish together
        for (int k = 0; k < DATA_W; k++) begin
            for (int c = 0; c < CHANNELS_DEF; c++)
                syms[2*c +: 2] = DIRECTED_BYTES[c][DATA_W-1-k] ? ONE_CODE_RST
                                                                : ZERO_CODE_RST;
            send_item(pack_syms(syms, 2'(k)));
        end
        send_item(pack_syms({CHANNELS_DEF{START_CODE_RST}}, 2'b11));
        repeat (3) send_item(pack_syms({CHANNELS_DEF{ZERO_CODE_RST}}, 2'b00));
        // ch0 restarts mid-byte, ch1 drops its byte
        send_item(pack_syms({{(CHANNELS_DEF-2){ZERO_CODE_RST}}, NOISE_SYM,
                             START_CODE_RST}, 2'b01));
        repeat (4) send_item(pack_syms({CHANNELS_DEF{ZERO_CODE_RST}}, 2'b10));
        repeat (4) send_item(pack_syms({CHANNELS_DEF{ONE_CODE_RST}}, 2'b11));
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random(RANDOM_PER_PHASE);

        set_codes(2'd0, 2'd3, 2'd1);
        hold_reqs <= hold_reqs + 1;
        run_random(RANDOM_PER_PHASE);

        set_codes(2'd2, 2'd0, 2'd3);
        run_random(RANDOM_PER_PHASE);

        set_codes(2'd1, 2'd1, 2'd1);
        run_random(RANDOM_PER_PHASE);

        set_codes(2'd0, 2'd2, 2'd0);
        run_random(RANDOM_PER_PHASE);

        drain();
        apb_write(REG_UNUSED, 2'($urandom()));
        set_codes(START_CODE_RST, ZERO_CODE_RST, ONE_CODE_RST);
        run_random(RANDOM_PER_PHASE);

        drain();
        repeat (10) @(posedge aclk);
        sb.close_out();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/mirsd_pkg.sv
sv/mirsd_lane.sv
sv/mirsd_merge.sv
sv/multichannel_ir_symbol_deframer_core.sv
sim/tb_multichannel_ir_symbol_deframer_core.sv
